// ===== hw/rtl/pidb_pkg.sv =====
package pidb_pkg;

  // Field and datapath widths
  localparam int DATA_W = 32;
  localparam int CFG_W  = 31;
  localparam int FRAC_W = 16;
  localparam int MUL_W  = 33;                // 32-bit signed, or error difference
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W - FRAC_W;   // floored product and three-term sum

  // Command codes
  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_UNSET  = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;

  // Status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_BAD_KP = 3'd2;
  localparam logic [2:0] ST_BAD_KI = 3'd3;
  localparam logic [2:0] ST_BAD_KD = 3'd4;
  localparam logic [2:0] ST_UNUSED = 3'd5;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_PERIOD = 1'b1;
  localparam logic [CFG_W-1:0] RST_UPDATE_PERIOD  = 31'd655;
  localparam logic [CFG_W-1:0] RST_INVERSE_PERIOD = 31'd6553600;

  typedef struct packed {
    logic [1:0]               command;
    logic [3:0]               slot;
    logic signed [DATA_W-1:0] gain_p;
    logic signed [DATA_W-1:0] gain_i;
    logic signed [DATA_W-1:0] gain_d;
    logic signed [DATA_W-1:0] integral_limit;
    logic signed [DATA_W-1:0] target;
    logic signed [DATA_W-1:0] measured;
  } in_item_t;

  typedef struct packed {
    logic [2:0]               status;
    logic [3:0]               slot_id;
    logic signed [DATA_W-1:0] drive;
  } out_item_t;

  // One slot's stored context, kept as one memory word
  typedef struct packed {
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki;
    logic signed [DATA_W-1:0] kd;
    logic signed [DATA_W-1:0] limit;
    logic signed [DATA_W-1:0] integ;
    logic signed [DATA_W-1:0] prev;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL_I,
    S_MUL_D,
    S_MUL_P,
    S_MUL_KI,
    S_MUL_KD,
    S_SUM,
    S_WB,
    S_DONE
  } state_t;

  // Saturate a wide signed value to 32 bits
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-DATA_W:0] top;
    top = v[ACC_W-1:DATA_W-1];
    if ((&top) || !(|top)) begin
      return v[DATA_W-1:0];
    end else if (v[ACC_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // Q16.16 product back to Q16.16, rounding toward minus infinity
  function automatic logic signed [ACC_W-1:0] floor_q16(input logic signed [PROD_W-1:0] p);
    return p[PROD_W-1:FRAC_W];
  endfunction

endpackage

// ===== hw/rtl/pidb_ram.sv =====
module pidb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/pidb_mul.sv =====
module pidb_mul
  import pidb_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] prod_r
);

  // shared signed multiplier, product registered
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

endmodule

// ===== hw/rtl/pid_controller_bank_core.sv =====
// PID controller bank, SLOT_COUNT slots of signed Q16.16 controllers.
//
// Input channel (in_valid/in_ready/in_data): one command word per handshake.
//   set    - check gains (kp, ki, kd in that order), take lowest free slot,
//            store gains and integral upper limit, report slot in slot_id.
//   unset  - free a slot.
//   update - e = target - measured, I = min(I + e*dt, limit),
//            D = (e - e_prev) * (1/dt); drive = kp*e + ki*I + kd*D, saturated.
// Output channel (out_valid/out_ready/out_data): exactly one result word per
//   command. An output register holds it while the receiver stalls; the core
//   finishes the next command and then waits until that register is free.
// Config port: cfg_we/cfg_index/cfg_wdata writes dt and 1/dt, no read-back.
// Timing: one command at a time, in_ready is high only in idle. The core returns
//   to idle as it loads the result into the output register. Update is bound by
//   the single 33x33 multiplier, used five times in sequence; slot context sits
//   in one RAM word per slot.
// Reset (rst_n, synchronous): all slots free, config to defaults, no result
//   pending. Slot memory is not cleared; only a slot written by a set is used.
module pid_controller_bank_core
  import pidb_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int SLOT_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ENTRY_W = $bits(entry_t);

  // control state
  state_t                  state_r, state_nxt;
  logic [SLOT_COUNT-1:0]   used_r, used_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CFG_W-1:0]        dt_r;
  logic [CFG_W-1:0]        inv_r;

  // payload
  in_item_t                in_r, in_nxt;
  logic signed [DATA_W-1:0] e_r, e_nxt;
  logic signed [DATA_W-1:0] ival_r, ival_nxt;
  logic signed [DATA_W-1:0] dval_r, dval_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  out_item_t               res_r, res_nxt;
  out_item_t               out_data_r, out_data_nxt;

  // slot memory
  logic                    ram_we;
  logic [SLOT_W-1:0]       ram_waddr;
  entry_t                  ram_wdata;
  logic                    ram_re;
  logic [SLOT_W-1:0]       ram_raddr;
  entry_t                  ram_rdata;

  // multiplier
  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  prod_floor;

  // slot decode and free-slot search
  logic [SLOT_W-1:0]       slot_idx;
  logic                    slot_ok;
  logic                    slot_live;
  logic [SLOT_COUNT-1:0]   free_vec;
  logic [SLOT_COUNT-1:0]   free_low;
  logic [SLOT_W-1:0]       free_idx;

  // integral step
  logic signed [ACC_W-1:0]  isum;
  logic signed [DATA_W-1:0] isat;

  pidb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  pidb_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  assign prod_floor = floor_q16(prod_r);

  // slots above the bank count as free
  assign slot_idx  = SLOT_W'(in_r.slot);
  assign slot_ok   = 32'(in_r.slot) < SLOT_COUNT;
  assign slot_live = slot_ok && used_r[slot_idx];

  // lowest free slot: isolate lowest set bit, then encode the one-hot
  assign free_vec = ~used_r;
  assign free_low = free_vec & (~free_vec + SLOT_COUNT'(1));

  always_comb begin
    free_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (free_low[i]) begin
        free_idx = free_idx | SLOT_W'(i);
      end
    end
  end

  // I + e*dt, saturated, upper clamp only
  assign isum = ACC_W'(ram_rdata.integ) + prod_floor;
  assign isat = sat32(isum);

  // read slot context as the word is taken; held until the next accept
  assign ram_re    = in_valid && in_ready;
  assign ram_raddr = SLOT_W'(in_data.slot);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    used_nxt      = used_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    in_nxt        = in_r;
    e_nxt         = e_r;
    ival_nxt      = ival_r;
    dval_nxt      = dval_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    ram_we        = 1'b0;
    ram_waddr     = slot_idx;
    ram_wdata     = ram_rdata;
    mul_a         = '0;
    mul_b         = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_data;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        res_nxt   = '0;
        state_nxt = S_DONE;
        e_nxt     = sat32(ACC_W'(in_r.target) - ACC_W'(in_r.measured));
        unique case (in_r.command)
          CMD_SET: begin
            if (in_r.gain_p[DATA_W-1]) begin
              res_nxt.status = ST_BAD_KP;
            end else if (in_r.gain_i[DATA_W-1]) begin
              res_nxt.status = ST_BAD_KI;
            end else if (in_r.gain_d[DATA_W-1]) begin
              res_nxt.status = ST_BAD_KD;
            end else if (&used_r) begin
              res_nxt.status = ST_FULL;
            end else begin
              used_nxt[free_idx] = 1'b1;
              ram_we             = 1'b1;
              ram_waddr          = free_idx;
              ram_wdata.kp       = in_r.gain_p;
              ram_wdata.ki       = in_r.gain_i;
              ram_wdata.kd       = in_r.gain_d;
              ram_wdata.limit    = in_r.integral_limit;
              ram_wdata.integ    = '0;
              ram_wdata.prev     = '0;
              res_nxt.slot_id    = 4'(free_idx);
            end
          end
          CMD_UNSET: begin
            if (!slot_live) begin
              res_nxt.status = ST_UNUSED;
            end
            if (slot_ok) begin
              used_nxt[slot_idx] = 1'b0;
            end
          end
          CMD_UPDATE: begin
            if (!slot_live) begin
              res_nxt.status = ST_UNUSED;
            end else begin
              state_nxt = S_MUL_I;
            end
          end
          default: begin
            // no-op command: zero result
          end
        endcase
      end

      S_MUL_I: begin
        mul_a     = MUL_W'(e_r);
        mul_b     = MUL_W'(dt_r);
        state_nxt = S_MUL_D;
      end

      S_MUL_D: begin
        mul_a     = MUL_W'(e_r) - MUL_W'(ram_rdata.prev);
        mul_b     = MUL_W'(inv_r);
        ival_nxt  = (isat > ram_rdata.limit) ? ram_rdata.limit : isat;
        state_nxt = S_MUL_P;
      end

      S_MUL_P: begin
        mul_a     = MUL_W'(ram_rdata.kp);
        mul_b     = MUL_W'(e_r);
        dval_nxt  = sat32(prod_floor);
        state_nxt = S_MUL_KI;
      end

      S_MUL_KI: begin
        mul_a     = MUL_W'(ram_rdata.ki);
        mul_b     = MUL_W'(ival_r);
        acc_nxt   = prod_floor;
        state_nxt = S_MUL_KD;
      end

      S_MUL_KD: begin
        mul_a     = MUL_W'(ram_rdata.kd);
        mul_b     = MUL_W'(dval_r);
        acc_nxt   = acc_r + prod_floor;
        state_nxt = S_SUM;
      end

      S_SUM: begin
        acc_nxt   = acc_r + prod_floor;
        state_nxt = S_WB;
      end

      S_WB: begin
        ram_we          = 1'b1;
        ram_wdata.integ = ival_r;
        ram_wdata.prev  = e_r;
        res_nxt.drive   = sat32(acc_r);
        state_nxt       = S_DONE;
      end

      S_DONE: begin
        // load the output word once the register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      dt_r        <= RST_UPDATE_PERIOD;
      inv_r       <= RST_INVERSE_PERIOD;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_UPDATE_PERIOD:  dt_r  <= cfg_wdata;
          CFG_INVERSE_PERIOD: inv_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    e_r        <= e_nxt;
    ival_r     <= ival_nxt;
    dval_r     <= dval_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // slot memory is written only by a set in decode or by update write-back
  a_ram_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_DECODE || state_r == S_WB))
    else $error("slot memory written outside decode or write-back");

  // occupancy changes only as the result of decoding a command
  a_used_from_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (used_r != $past(used_r)) |-> ($past(state_r) == S_DECODE))
    else $error("slot occupancy changed outside decode");

  // stored integral never exceeds the slot's upper limit
  a_integral_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |-> (ival_r <= ram_rdata.limit))
    else $error("integral above its limit at write-back");

  // a new result word appears only out of the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result word raised outside done state");

endmodule

// ===== bench/pid_controller_bank_core_checker.sv =====
`timescale 1ns / 100ps

module pid_controller_bank_core_checker
  import pidb_pkg::*;
#(
  parameter int SLOT_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  output int                   fail_count,
  output int                   pending_cnt
);

  // wide enough for (33-bit difference) x (31-bit period) with no wrap
  typedef logic signed [79:0] wide_t;

  localparam wide_t MAX32 = 80'sd2147483647;
  localparam wide_t MIN32 = -80'sd2147483648;

  logic [CFG_W-1:0]         dt_q;
  logic [CFG_W-1:0]         inv_dt_q;
  logic                     used_q  [SLOT_COUNT];
  logic signed [DATA_W-1:0] kp_q    [SLOT_COUNT];
  logic signed [DATA_W-1:0] ki_q    [SLOT_COUNT];
  logic signed [DATA_W-1:0] kd_q    [SLOT_COUNT];
  logic signed [DATA_W-1:0] limit_q [SLOT_COUNT];
  logic signed [DATA_W-1:0] integ_q [SLOT_COUNT];
  logic signed [DATA_W-1:0] prev_q  [SLOT_COUNT];

  out_item_t expected_q[$];
  out_item_t want;
  int        errs = 0;

  assign fail_count = errs;

  function automatic logic signed [DATA_W-1:0] clamp32(wide_t v);
    if (v > MAX32) begin
      return 32'sh7FFF_FFFF;
    end
    if (v < MIN32) begin
      return 32'sh8000_0000;
    end
    return v[DATA_W-1:0];
  endfunction

  function automatic void free_slot(int s);
    used_q[s]  = 1'b0;
    kp_q[s]    = '0;
    ki_q[s]    = '0;
    kd_q[s]    = '0;
    limit_q[s] = '0;
    integ_q[s] = '0;
    prev_q[s]  = '0;
  endfunction

  // Expected response to one command word; updates the slot bank.
  function automatic out_item_t pid_response(in_item_t w);
    out_item_t                r;
    wide_t                    tgt_w, meas_w, err_w, prev_w, dt_w, inv_w;
    wide_t                    acc, kp_w, ki_w, kd_w, i_w, d_w;
    logic signed [DATA_W-1:0] e32, i32, d32;
    int                       s;
    r = '0;
    s = int'(w.slot);
    case (w.command)
      CMD_SET: begin
        if (w.gain_p[DATA_W-1]) begin
          r.status = ST_BAD_KP;
        end else if (w.gain_i[DATA_W-1]) begin
          r.status = ST_BAD_KI;
        end else if (w.gain_d[DATA_W-1]) begin
          r.status = ST_BAD_KD;
        end else begin
          s = 0;
          while (s < SLOT_COUNT && used_q[s]) begin
            s++;
          end
          if (s >= SLOT_COUNT) begin
            r.status = ST_FULL;
          end else begin
            used_q[s]  = 1'b1;
            kp_q[s]    = w.gain_p;
            ki_q[s]    = w.gain_i;
            kd_q[s]    = w.gain_d;
            limit_q[s] = w.integral_limit;
            integ_q[s] = '0;
            prev_q[s]  = '0;
            r.slot_id  = s[3:0];
          end
        end
      end
      CMD_UNSET: begin
        if (s < SLOT_COUNT) begin
          if (!used_q[s]) begin
            r.status = ST_UNUSED;
          end
          free_slot(s);
        end else begin
          r.status = ST_UNUSED;
        end
      end
      CMD_UPDATE: begin
        if (s >= SLOT_COUNT || !used_q[s]) begin
          r.status = ST_UNUSED;
        end else begin
          tgt_w  = wide_t'(w.target);
          meas_w = wide_t'(w.measured);
          e32    = clamp32(tgt_w - meas_w);
          err_w  = wide_t'(e32);
          dt_w   = {49'd0, dt_q};
          inv_w  = {49'd0, inv_dt_q};
          // integral: saturate, then upper clamp only
          acc = wide_t'(integ_q[s]);
          acc = acc + ((err_w * dt_w) >>> FRAC_W);
          i32 = clamp32(acc);
          if (i32 > limit_q[s]) begin
            i32 = limit_q[s];
          end
          prev_w = wide_t'(prev_q[s]);
          acc    = ((err_w - prev_w) * inv_w) >>> FRAC_W;
          d32    = clamp32(acc);
          kp_w   = wide_t'(kp_q[s]);
          ki_w   = wide_t'(ki_q[s]);
          kd_w   = wide_t'(kd_q[s]);
          i_w    = wide_t'(i32);
          d_w    = wide_t'(d32);
          acc = ((kp_w * err_w) >>> FRAC_W) + ((ki_w * i_w) >>> FRAC_W)
              + ((kd_w * d_w) >>> FRAC_W);
          r.drive    = clamp32(acc);
          integ_q[s] = i32;
          prev_q[s]  = e32;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      dt_q     = RST_UPDATE_PERIOD;
      inv_dt_q = RST_INVERSE_PERIOD;
      for (int k = 0; k < SLOT_COUNT; k++) begin
        free_slot(k);
      end
      expected_q.delete();
      pending_cnt <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_UPDATE_PERIOD:  dt_q     = cfg_wdata;
          CFG_INVERSE_PERIOD: inv_dt_q = cfg_wdata;
          default: ;
        endcase
      end
      // results leave before a same-edge command is queued
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          errs++;
          $display("%0t: result word with none expected: status %0d slot %0d drive %0d",
                   $time, out_data.status, out_data.slot_id, $signed(out_data.drive));
        end else begin
          want = expected_q.pop_front();
          if (out_data.status !== want.status) begin
            errs++;
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, out_data.status);
          end
          if (out_data.slot_id !== want.slot_id) begin
            errs++;
            $display("%0t: slot_id mismatch, expected %0d, got %0d",
                     $time, want.slot_id, out_data.slot_id);
          end
          if (out_data.drive !== want.drive) begin
            errs++;
            $display("%0t: drive mismatch, expected %0d, got %0d",
                     $time, $signed(want.drive), $signed(out_data.drive));
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_q.push_back(pid_response(in_data));
      end
      pending_cnt <= expected_q.size();
    end
  end

endmodule

// ===== bench/pid_controller_bank_core_tb.sv =====
`timescale 1ns / 100ps

module pid_controller_bank_core_tb;
  import pidb_pkg::*;

  // command 3 has no package name: the core treats it as a no-op
  localparam logic [1:0] CMD_NOP = 2'd3;

  // the slowest legal run ends well inside this watchdog limit
  localparam int CYCLE_LIMIT = 400000;

  // receiver hold-off used to back the core up into its input
  localparam int HOLD_CYCLES = 300;

  localparam int PHASE_WORDS = 180;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  int fail_count;
  int pending_cnt;

  // knobs for the two sides, in percent of cycles
  int sender_idle = 0;
  int stall_pct   = 0;

  // a bump of hold_seq asks the receiver process for one long hold-off
  int hold_seq    = 0;
  int hold_seen   = 0;
  int hold_left   = 0;

  int cycle_cnt   = 0;

  // slots the stimulus believes are taken; only steers slot choice
  logic [15:0] busy_mask = '0;

  pid_controller_bank_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pid_controller_bank_core_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending_cnt (pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("pid_controller_bank_core verification failed");
      $finish;
    end
  end

  // Receiver: random stalls at stall_pct, or a long hold-off on request.
  // The hold is counted here so the sender keeps pushing words meanwhile.
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Mostly small nonnegative gains so drive stays in range; some full-scale.
  function automatic logic signed [DATA_W-1:0] pick_gain();
    int r;
    r = $urandom_range(19);
    if (r < 14) begin
      return $urandom_range(32'h0004_0000, 0);
    end else if (r < 19) begin
      return $urandom & 32'h7FFF_FFFF;
    end
    return 32'h7FFF_FFFF;
  endfunction

  // Setpoint / measurement: small signed values, sometimes anything.
  function automatic logic signed [DATA_W-1:0] pick_level();
    if ($urandom_range(3) != 0) begin
      return $urandom_range(32'h0008_0000, 0) - 32'h0004_0000;
    end
    return $urandom;
  endfunction

  function automatic logic [3:0] pick_busy_slot();
    logic [3:0] s;
    if (busy_mask == '0) begin
      return 4'($urandom_range(15));
    end
    do begin
      s = 4'($urandom_range(15));
    end while (!busy_mask[s]);
    return s;
  endfunction

  // Random command word. Fields the command ignores still carry random bits.
  function automatic in_item_t random_word();
    in_item_t w;
    int       r;
    w.command        = CMD_NOP;
    w.slot           = 4'($urandom_range(15));
    w.gain_p         = $urandom;
    w.gain_i         = $urandom;
    w.gain_d         = $urandom;
    w.integral_limit = $urandom;
    w.target         = $urandom;
    w.measured       = $urandom;
    r = $urandom_range(99);
    if (r < 17) begin
      w.command = CMD_SET;
      w.gain_p  = pick_gain();
      w.gain_i  = pick_gain();
      w.gain_d  = pick_gain();
      if ($urandom_range(1) != 0) begin
        w.integral_limit = $urandom_range(32'h0020_0000, 0);
      end
      // a few sets with one negative gain
      if ($urandom_range(99) < 12) begin
        case ($urandom_range(2))
          0:       w.gain_p[DATA_W-1] = 1'b1;
          1:       w.gain_i[DATA_W-1] = 1'b1;
          default: w.gain_d[DATA_W-1] = 1'b1;
        endcase
      end
    end else if (r < 32) begin
      w.command = CMD_UNSET;
      if ($urandom_range(99) < 70) begin
        w.slot = pick_busy_slot();
      end
    end else if (r < 94) begin
      // updates mostly hit live slots so the integral and last error build up
      w.command = CMD_UPDATE;
      if ($urandom_range(99) < 88) begin
        w.slot = pick_busy_slot();
      end
      w.target   = pick_level();
      w.measured = pick_level();
    end
    return w;
  endfunction

  // Offer one word, hold it until taken, then maybe go idle for a while.
  // Valid stays up across back-to-back words.
  task automatic send_word(input in_item_t w);
    int gap;
    int k;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (w.command == CMD_SET && !w.gain_p[DATA_W-1] && !w.gain_i[DATA_W-1]
        && !w.gain_d[DATA_W-1]) begin
      for (k = 0; k < 16; k++) begin
        if (!busy_mask[k]) begin
          busy_mask[k] = 1'b1;
          break;
        end
      end
    end else if (w.command == CMD_UNSET) begin
      busy_mask[w.slot] = 1'b0;
    end
    gap = 0;
    while (gap < 40 && $urandom_range(99) < sender_idle) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue(input logic [1:0] cmd, input logic [3:0] slot,
                       input logic [31:0] kp, input logic [31:0] ki,
                       input logic [31:0] kd, input logic [31:0] lim,
                       input logic [31:0] tgt, input logic [31:0] meas);
    in_item_t w;
    w.command        = cmd;
    w.slot           = slot;
    w.gain_p         = kp;
    w.gain_i         = ki;
    w.gain_d         = kd;
    w.integral_limit = lim;
    w.target         = tgt;
    w.measured       = meas;
    send_word(w);
  endtask

  // Drop valid and wait for every expected result, then a few quiet cycles.
  // Every word yields a result, so the core is idle once the queue is empty.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (6) @(posedge clk);
  endtask

  // Both period registers, back to back, with the core idle.
  task automatic program_periods(input logic [CFG_W-1:0] dt,
                                 input logic [CFG_W-1:0] inv_dt);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_UPDATE_PERIOD;
    cfg_wdata <= dt;
    @(posedge clk);
    cfg_index <= CFG_INVERSE_PERIOD;
    cfg_wdata <= inv_dt;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input int idle, input int stall,
                           input logic [CFG_W-1:0] dt,
                           input logic [CFG_W-1:0] inv_dt, input bit hold);
    settle();
    program_periods(dt, inv_dt);
    sender_idle = idle;
    stall_pct  <= stall;
    if (hold) begin
      hold_seq <= hold_seq + 1;
    end
    repeat (PHASE_WORDS) begin
      send_word(random_word());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed words, reset periods, no idling ----
    // full-scale kp, zero ki/kd -> slot 0
    issue(CMD_SET, 4'd0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0);
    // negative gains, checked kp then ki then kd
    issue(CMD_SET, 4'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(CMD_SET, 4'd0, 32'h1, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(CMD_SET, 4'd0, 32'h0, 32'h0, 32'h8000_0001, 32'h0, 32'h0, 32'h0);
    // max ki/kd with the most negative integral limit -> slot 1
    issue(CMD_SET, 4'd0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
          32'h0, 32'h0);
    // error saturates both ways; drive saturates
    issue(CMD_UPDATE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
    issue(CMD_UPDATE, 4'd0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
    issue(CMD_UPDATE, 4'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0);
    // update and unset of a free slot, unset of a live one, then update it
    issue(CMD_UPDATE, 4'd15, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1234_5678, 32'h0);
    issue(CMD_UNSET, 4'd15, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(CMD_UNSET, 4'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    issue(CMD_UPDATE, 4'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0);
    // no-op command with every field set
    issue(CMD_NOP, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
          32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fill slots 1..15, the last set finds the bank full
    repeat (16) begin
      issue(CMD_SET, 4'd0, 32'h0000_8000, 32'h0000_0100, 32'h0000_0040, 32'h0001_0000,
            32'h0, 32'h0);
    end

    // ---- random phases ----
    // reset periods, no idling; receiver holds off long at the start
    run_phase(0, 0, RST_UPDATE_PERIOD, RST_INVERSE_PERIOD, 1'b1);
    // smallest dt, largest 1/dt, sender mostly idle
    run_phase(73, 0, 31'd1, 31'h7FFF_FFFF, 1'b0);
    // largest dt, smallest 1/dt, receiver mostly stalled
    run_phase(0, 73, 31'h7FFF_FFFF, 31'd1, 1'b0);
    // both at max, light idling on both sides
    run_phase(16, 16, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b0);
    // moderate random periods, no idling
    run_phase(0, 0, 31'($urandom_range(32'h0002_0000, 1)),
              31'($urandom_range(32'h7FFF_FFFF, 1)), 1'b0);

    // drain, then let the core sit a while to catch any stray result word
    settle();
    repeat (14) @(posedge clk);
    if (fail_count == 0) begin
      $display("pid_controller_bank_core verification clean");
    end else begin
      $display("pid_controller_bank_core verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pidb_pkg.sv
hw/rtl/pidb_ram.sv
hw/rtl/pidb_mul.sv
hw/rtl/pid_controller_bank_core.sv
bench/pid_controller_bank_core_checker.sv
bench/pid_controller_bank_core_tb.sv
